>>> sv/mhs_pkg.sv
package mhs_pkg;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int COEF_W  = 21;
    localparam int KMER_W  = 32;
    localparam int HCNT_W  = 7;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - SLOT_W - KMER_W;

    localparam int MAX_HASHES_DEF = 64;
    localparam int PRIME_DEF      = 1048583;

    localparam logic [HCNT_W-1:0] HCNT_RESET = 7'd32;

    // Bits of the k-mer consumed by each stage of the hash pipeline.
    localparam int STEP_BITS = 2;
    localparam int NUM_STAGES = KMER_W / STEP_BITS;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KMER   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_KMER,
        ST_DRAIN,
        ST_EMIT
    } mhs_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [KMER_W-1:0] kmer;
    } mhs_tag_t;

endpackage

>>> sv/mhs_hash_pipe.sv
module mhs_hash_pipe #(
    parameter int PRIME = mhs_pkg::PRIME_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [$clog2(PRIME)-1:0] in_a,
    input  logic [$clog2(PRIME)-1:0] in_b,
    input  mhs_pkg::mhs_tag_t    in_tag,
    output logic                 out_valid,
    output logic [$clog2(PRIME)-1:0] out_hash,
    output mhs_pkg::mhs_tag_t    out_tag,
    output logic                 busy
);

    localparam int PW  = $clog2(PRIME);
    localparam int PW1 = PW + 1;
    localparam int NST = mhs_pkg::NUM_STAGES;
    localparam int SB  = mhs_pkg::STEP_BITS;
    localparam int KW  = mhs_pkg::KMER_W;
    localparam logic [PW:0] P_EXT = PW1'(PRIME);

    logic [NST-1:0]    st_v_reg;
    logic [PW-1:0]     st_r_reg   [NST];
    logic [PW-1:0]     st_a_reg   [NST];
    logic [PW-1:0]     st_b_reg   [NST];
    mhs_pkg::mhs_tag_t st_tag_reg [NST];
    logic [PW-1:0]     st_r_next  [NST];

    logic              out_v_reg;
    logic [PW-1:0]     out_hash_reg;
    mhs_pkg::mhs_tag_t out_tag_reg;
    logic [PW-1:0]     hash_next;

    // One Horner step: r = (2 * r + kb * a) mod PRIME, with r and a reduced.
    function automatic logic [PW-1:0] dbl_add(input logic [PW-1:0] r,
                                              input logic [PW-1:0] a,
                                              input logic kb);
        logic [PW:0] t;
        t = {r, 1'b0};
        if (t >= P_EXT) begin
            t = t - P_EXT;
        end
        if (kb) begin
            t = t + {1'b0, a};
        end
        if (t >= P_EXT) begin
            t = t - P_EXT;
        end
        return t[PW-1:0];
    endfunction

    always_comb begin
        logic [PW-1:0] r;
        logic [PW-1:0] a;
        logic [KW-1:0] k;
        for (int s = 0; s < NST; s++) begin
            if (s == 0) begin
                r = '0;
                a = in_a;
                k = in_tag.kmer;
            end else begin
                r = st_r_reg[s-1];
                a = st_a_reg[s-1];
                k = st_tag_reg[s-1].kmer;
            end
            for (int j = 0; j < SB; j++) begin
                r = dbl_add(r, a, k[KW-1-s*SB-j]);
            end
            st_r_next[s] = r;
        end
    end

    always_comb begin
        logic [PW:0] t;
        t = {1'b0, st_r_reg[NST-1]} + {1'b0, st_b_reg[NST-1]};
        if (t >= P_EXT) begin
            t = t - P_EXT;
        end
        hash_next = t[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            st_v_reg  <= {st_v_reg[NST-2:0], in_valid};
            out_v_reg <= st_v_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NST; s++) begin
            st_r_reg[s] <= st_r_next[s];
            if (s == 0) begin
                st_a_reg[s]   <= in_a;
                st_b_reg[s]   <= in_b;
                st_tag_reg[s] <= in_tag;
            end else begin
                st_a_reg[s]   <= st_a_reg[s-1];
                st_b_reg[s]   <= st_b_reg[s-1];
                st_tag_reg[s] <= st_tag_reg[s-1];
            end
        end
        out_hash_reg <= hash_next;
        out_tag_reg  <= st_tag_reg[NST-1];
    end

    assign out_valid = out_v_reg;
    assign out_hash  = out_hash_reg;
    assign out_tag   = out_tag_reg;
    assign busy      = (|st_v_reg) || out_v_reg;

endmodule

>>> sv/minhash_signature_engine.sv
// A k-mer item holds off the input port while the active slots are issued: one slot
// a cycle is read from the coefficient memories and sent into a 17-stage modular hash pipeline,
// then compared against the minimum memories. A k-mer of zero is ignored.
// A load item reduces the coefficients by a reciprocal multiply before storing them.
// A finish item waits for the pipeline to drain, then emits one result per cycle under m_tready.
// Reset clears control, the chunk state and sets hash_count to 32; coefficients are not cleared.
module minhash_signature_engine #(
    parameter int MAX_HASHES = mhs_pkg::MAX_HASHES_DEF,
    parameter int PRIME      = mhs_pkg::PRIME_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot_index, coef_a, coef_b, kmer
    input  logic [mhs_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  logic [mhs_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // signature_value, slot, zero padding
    output logic [mhs_pkg::M_TDATA_W-1:0]   m_tdata,
    // kmers_found
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mhs_pkg::HCNT_W-1:0]      cfg_data
);

    localparam int AW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int PW    = $clog2(PRIME);
    localparam int HW    = mhs_pkg::HCNT_W;
    localparam int SW    = mhs_pkg::SLOT_W;
    localparam int CW    = mhs_pkg::COEF_W;
    localparam int KW    = mhs_pkg::KMER_W;
    localparam int LDC_W = 1;
    localparam logic [CW-1:0]    P_CW    = CW'(PRIME);
    localparam logic [CW-1:0]    RECIP   = CW'((64'd1 << CW) / PRIME);
    localparam logic [HW-1:0]    MAX_H   = HW'(MAX_HASHES);
    localparam logic [HW-1:0]    ONE_H   = HW'(1);
    localparam logic [LDC_W-1:0] LD_LAST = LDC_W'(1);

    mhs_pkg::mhs_state_t state_reg, state_next;

    logic [mhs_pkg::KIND_W-1:0] in_kind;
    logic [SW-1:0]              in_slot;
    logic [CW-1:0]              in_coef_a;
    logic [CW-1:0]              in_coef_b;
    logic [KW-1:0]              in_kmer;
    logic                       s_accept;

    logic [HW-1:0]   hcnt_reg;
    logic [HW-1:0]   n_act;
    logic            any_seen_reg;
    logic [MAX_HASHES-1:0] slot_valid_reg;

    logic [PW-1:0] coef_a_mem   [MAX_HASHES];
    logic [PW-1:0] coef_b_mem   [MAX_HASHES];
    logic [PW-1:0] min_hash_mem [MAX_HASHES];
    logic [KW-1:0] min_kmer_mem [MAX_HASHES];

    logic [LDC_W-1:0] ld_cnt_reg;
    logic [SW-1:0]    ld_slot_reg;
    logic [CW-1:0]    ld_a_reg;
    logic [CW-1:0]    ld_b_reg;
    logic [CW-1:0]    qa_reg;
    logic [CW-1:0]    qb_reg;
    logic [CW-1:0]    qa_next;
    logic [CW-1:0]    qb_next;
    logic [PW-1:0]    ra_next;
    logic [PW-1:0]    rb_next;

    logic [HW-1:0]     issue_idx_reg;
    logic [KW-1:0]     kmer_reg;
    logic              cv_reg;
    logic [PW-1:0]     coef_a_rd_reg;
    logic [PW-1:0]     coef_b_rd_reg;
    mhs_pkg::mhs_tag_t c_tag_reg;

    logic              pipe_valid;
    logic [PW-1:0]     pipe_hash;
    mhs_pkg::mhs_tag_t pipe_tag;
    logic              pipe_busy;
    logic              busy;

    logic [AW-1:0]     min_rd_addr;
    logic              min_rd_en;
    logic [PW-1:0]     min_hash_rd_reg;
    logic [KW-1:0]     min_kmer_rd_reg;
    logic              u_v_reg;
    logic [PW-1:0]     u_hv_reg;
    mhs_pkg::mhs_tag_t u_tag_reg;
    logic              u_take;

    logic [HW-1:0] emit_idx_reg;
    logic          emit_issue;
    logic          a_free;
    logic          b_load;
    logic          a_v_reg;
    logic          a_sv_reg;
    logic [SW-1:0] a_slot_reg;
    logic          a_last_reg;
    logic          m_valid_reg;
    logic [KW-1:0] m_sig_reg;
    logic [SW-1:0] m_slot_reg;
    logic          m_found_reg;
    logic          m_last_reg;

    assign in_kind   = s_tuser;
    assign in_slot   = s_tdata[SW-1:0];
    assign in_coef_a = s_tdata[SW+CW-1:SW];
    assign in_coef_b = s_tdata[SW+2*CW-1:SW+CW];
    assign in_kmer   = s_tdata[SW+2*CW+KW-1:SW+2*CW];
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (hcnt_reg == '0) begin
            n_act = ONE_H;
        end else if (hcnt_reg > MAX_H) begin
            n_act = MAX_H;
        end else begin
            n_act = hcnt_reg;
        end
    end

    // The estimated quotient is at most one below the true one, so one
    // conditional subtraction finishes the remainder.
    always_comb begin
        logic [2*CW-1:0] pa;
        logic [2*CW-1:0] pb;
        logic [CW-1:0]   da;
        logic [CW-1:0]   db;
        pa = (2*CW)'(ld_a_reg) * (2*CW)'(RECIP);
        pb = (2*CW)'(ld_b_reg) * (2*CW)'(RECIP);
        qa_next = pa[2*CW-1:CW];
        qb_next = pb[2*CW-1:CW];
        da = ld_a_reg - qa_reg * P_CW;
        db = ld_b_reg - qb_reg * P_CW;
        if (da >= P_CW) begin
            da = da - P_CW;
        end
        if (db >= P_CW) begin
            db = db - P_CW;
        end
        ra_next = da[PW-1:0];
        rb_next = db[PW-1:0];
    end

    assign busy = cv_reg || pipe_busy || u_v_reg;

    always_comb begin
        state_next = state_reg;
        s_tready   = (state_reg == mhs_pkg::ST_IDLE);
        case (state_reg)
            mhs_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_kind)
                        mhs_pkg::KIND_LOAD: begin
                            state_next = mhs_pkg::ST_LOAD;
                        end
                        mhs_pkg::KIND_KMER: begin
                            if (in_kmer != '0) begin
                                state_next = mhs_pkg::ST_KMER;
                            end
                        end
                        mhs_pkg::KIND_FINISH: begin
                            state_next = mhs_pkg::ST_DRAIN;
                        end
                        default: begin
                            state_next = mhs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mhs_pkg::ST_LOAD: begin
                if (ld_cnt_reg == LD_LAST) begin
                    state_next = mhs_pkg::ST_IDLE;
                end
            end
            mhs_pkg::ST_KMER: begin
                if (issue_idx_reg == n_act - ONE_H) begin
                    state_next = mhs_pkg::ST_IDLE;
                end
            end
            mhs_pkg::ST_DRAIN: begin
                if (!busy) begin
                    state_next = mhs_pkg::ST_EMIT;
                end
            end
            mhs_pkg::ST_EMIT: begin
                if (emit_idx_reg == n_act && !a_v_reg) begin
                    state_next = mhs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mhs_pkg::ST_IDLE;
            end
        endcase
    end

    assign b_load     = a_v_reg && (!m_valid_reg || m_tready);
    assign a_free     = !a_v_reg || b_load;
    assign emit_issue = (state_reg == mhs_pkg::ST_EMIT) && (emit_idx_reg != n_act) && a_free;

    assign min_rd_addr = (state_reg == mhs_pkg::ST_EMIT) ? emit_idx_reg[AW-1:0]
                                                         : pipe_tag.slot[AW-1:0];
    assign min_rd_en   = (state_reg == mhs_pkg::ST_EMIT) ? emit_issue : 1'b1;

    assign u_take = u_v_reg
                 && (!slot_valid_reg[u_tag_reg.slot[AW-1:0]]
                     || u_hv_reg < min_hash_rd_reg
                     || (u_hv_reg == min_hash_rd_reg && u_tag_reg.kmer < min_kmer_rd_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mhs_pkg::ST_IDLE;
            hcnt_reg       <= mhs_pkg::HCNT_RESET;
            any_seen_reg   <= 1'b0;
            slot_valid_reg <= '0;
            ld_cnt_reg     <= '0;
            issue_idx_reg  <= '0;
            emit_idx_reg   <= '0;
            cv_reg         <= 1'b0;
            u_v_reg        <= 1'b0;
            a_v_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                hcnt_reg <= cfg_data;
            end
            if (state_reg == mhs_pkg::ST_IDLE) begin
                ld_cnt_reg    <= '0;
                issue_idx_reg <= '0;
                emit_idx_reg  <= '0;
                if (s_accept && in_kind == mhs_pkg::KIND_KMER && in_kmer != '0) begin
                    any_seen_reg <= 1'b1;
                end
            end
            if (state_reg == mhs_pkg::ST_LOAD) begin
                ld_cnt_reg <= ld_cnt_reg + LDC_W'(1);
            end
            if (state_reg == mhs_pkg::ST_KMER) begin
                issue_idx_reg <= issue_idx_reg + ONE_H;
            end
            if (emit_issue) begin
                emit_idx_reg <= emit_idx_reg + ONE_H;
            end
            if (u_take) begin
                slot_valid_reg[u_tag_reg.slot[AW-1:0]] <= 1'b1;
            end
            if (state_reg == mhs_pkg::ST_EMIT && state_next == mhs_pkg::ST_IDLE) begin
                slot_valid_reg <= '0;
                any_seen_reg   <= 1'b0;
            end
            cv_reg  <= (state_reg == mhs_pkg::ST_KMER);
            u_v_reg <= pipe_valid;
            if (emit_issue) begin
                a_v_reg <= 1'b1;
            end else if (b_load) begin
                a_v_reg <= 1'b0;
            end
            if (b_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mhs_pkg::ST_IDLE && s_accept) begin
            kmer_reg    <= in_kmer;
            ld_slot_reg <= in_slot;
            ld_a_reg    <= in_coef_a;
            ld_b_reg    <= in_coef_b;
        end
        if (state_reg == mhs_pkg::ST_LOAD && ld_cnt_reg != LD_LAST) begin
            qa_reg <= qa_next;
            qb_reg <= qb_next;
        end
        if (state_reg == mhs_pkg::ST_LOAD && ld_cnt_reg == LD_LAST
                && HW'(ld_slot_reg) < MAX_H) begin
            coef_a_mem[ld_slot_reg[AW-1:0]] <= ra_next;
            coef_b_mem[ld_slot_reg[AW-1:0]] <= rb_next;
        end
    end

    always_ff @(posedge aclk) begin
        coef_a_rd_reg  <= coef_a_mem[issue_idx_reg[AW-1:0]];
        coef_b_rd_reg  <= coef_b_mem[issue_idx_reg[AW-1:0]];
        c_tag_reg.slot <= issue_idx_reg[SW-1:0];
        c_tag_reg.kmer <= kmer_reg;
    end

    mhs_hash_pipe #(
        .PRIME(PRIME)
    ) u_hash_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cv_reg),
        .in_a      (coef_a_rd_reg),
        .in_b      (coef_b_rd_reg),
        .in_tag    (c_tag_reg),
        .out_valid (pipe_valid),
        .out_hash  (pipe_hash),
        .out_tag   (pipe_tag),
        .busy      (pipe_busy)
    );

    always_ff @(posedge aclk) begin
        if (min_rd_en) begin
            min_hash_rd_reg <= min_hash_mem[min_rd_addr];
            min_kmer_rd_reg <= min_kmer_mem[min_rd_addr];
        end
        u_hv_reg  <= pipe_hash;
        u_tag_reg <= pipe_tag;
        if (u_take) begin
            min_hash_mem[u_tag_reg.slot[AW-1:0]] <= u_hv_reg;
            min_kmer_mem[u_tag_reg.slot[AW-1:0]] <= u_tag_reg.kmer;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_issue) begin
            a_sv_reg   <= slot_valid_reg[emit_idx_reg[AW-1:0]];
            a_slot_reg <= emit_idx_reg[SW-1:0];
            a_last_reg <= (emit_idx_reg == n_act - ONE_H);
        end
        if (b_load) begin
            m_sig_reg   <= a_sv_reg ? min_kmer_rd_reg : '0;
            m_slot_reg  <= a_slot_reg;
            m_found_reg <= any_seen_reg;
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{mhs_pkg::M_PAD_W{1'b0}}, m_slot_reg, m_sig_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

endmodule
